// File: src/iqws_pkg.sv
// Shared types and codes of the issue queue with wakeup and select.
package iqws_pkg;

    localparam int ALU_MASK_W = 4;
    localparam int ALU_IDX_W  = 2;
    localparam int TAG_W      = 6;
    localparam int OPC_W      = 3;
    localparam int DATA_W     = 64;

    localparam logic [1:0] REQ_INSERT  = 2'd0;
    localparam logic [1:0] REQ_FORWARD = 2'd1;
    localparam logic [1:0] REQ_TICK    = 2'd2;

    localparam logic KIND_ISSUE = 1'b0;
    localparam logic KIND_FULL  = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0]  dest;
        logic [OPC_W-1:0]  opcode;
        logic [DATA_W-1:0] pc;
        logic              a_ready;
        logic [TAG_W-1:0]  a_tag;
        logic [DATA_W-1:0] a_value;
        logic              b_ready;
        logic [TAG_W-1:0]  b_tag;
        logic [DATA_W-1:0] b_value;
    } entry_t;

    typedef struct packed {
        logic                 kind;
        logic [ALU_IDX_W-1:0] alu_index;
        logic [TAG_W-1:0]     dest;
        logic [OPC_W-1:0]     opcode;
        logic [DATA_W-1:0]    pc;
        logic [DATA_W-1:0]    operand_a;
        logic [DATA_W-1:0]    operand_b;
    } result_t;

    typedef struct packed {
        logic                  issue;
        logic [ALU_IDX_W-1:0]  alu_index;
        logic [ALU_MASK_W-1:0] alu_ok;
    } step_res_t;

endpackage

// File: src/iqws_slot_ram.sv
// Slot storage of the issue queue: one write port, one registered read port.
module iqws_slot_ram
    import iqws_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  entry_t                   wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output entry_t                   rd_data
);

    entry_t slot_mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/iqws_step_unit.sv
// Per-entry tag wakeup and ALU pick, shared by every step of a queue scan.
module iqws_step_unit
    import iqws_pkg::*;
(
    input  entry_t                  entry,
    input  logic [TAG_W-1:0]        fwd_tag,
    input  logic [DATA_W-1:0]       fwd_value,
    input  logic [ALU_MASK_W-1:0]   alu_ok,
    output entry_t                  woken,
    output step_res_t               pick
);

    logic [ALU_IDX_W-1:0] low_alu;

    always_comb
    begin
        woken = entry;
        // Operands that already hold a value keep it
        if (!entry.a_ready && entry.a_tag == fwd_tag)
        begin
            woken.a_ready = 1'b1;
            woken.a_value = fwd_value;
        end
        if (!entry.b_ready && entry.b_tag == fwd_tag)
        begin
            woken.b_ready = 1'b1;
            woken.b_value = fwd_value;
        end
    end

    always_comb
    begin
        low_alu = '0;
        for (int i = ALU_MASK_W - 1; i >= 0; i--)
        begin
            if (alu_ok[i])
            begin
                low_alu = ALU_IDX_W'(i);
            end
        end
        pick.issue     = (alu_ok != '0) && entry.a_ready && entry.b_ready;
        pick.alu_index = low_alu;
        pick.alu_ok    = alu_ok & ~(ALU_MASK_W'(1) << low_alu);
    end

endmodule

// File: src/issue_queue_wakeup_select_top.sv
// Top level of the issue queue: request sequencer, slot storage and result output.
//
// An insert is written when accepted, and a refused insert passes to the flush state to
// place its result once the output register is free. A forward or an issue tick is
// accepted and then walks the occupied slots oldest first through the single slot RAM,
// a read state and an evaluate state per occupied slot (read, then wake or compact and
// write back), and a tick that issues anything hands over the final result in the flush
// state; a forward or tick on an empty queue, a tick with no usable free ALU, or one that
// the exception flag or an out-of-range tag turns away, is dropped. in_ready stays low
// during a walk and the handover. Results pass through a pending register and an output
// register, so a stalled consumer holds the walk only when an issued item is found while
// two earlier ones wait, and holds the final handover until the output register frees.
module issue_queue_wakeup_select_top
    import iqws_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 32,
    parameter int NUM_ALUS      = 4,
    parameter int NUM_PHYS_REGS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            req_type,
    input  logic [TAG_W-1:0]      dest_reg,
    input  logic [OPC_W-1:0]      opcode,
    input  logic [DATA_W-1:0]     pc,
    input  logic                  a_ready,
    input  logic [TAG_W-1:0]      a_tag,
    input  logic [DATA_W-1:0]     a_value,
    input  logic                  b_ready,
    input  logic [TAG_W-1:0]      b_tag,
    input  logic [DATA_W-1:0]     b_value,
    input  logic [ALU_MASK_W-1:0] alu_free_mask,
    input  logic                  exception_flag,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  kind,
    output logic [ALU_IDX_W-1:0]  alu_index,
    output logic [TAG_W-1:0]      out_dest,
    output logic [OPC_W-1:0]      out_opcode,
    output logic [DATA_W-1:0]     out_pc,
    output logic [DATA_W-1:0]     operand_a,
    output logic [DATA_W-1:0]     operand_b,
    output logic                  last
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ALU_LIM = (NUM_ALUS < ALU_MASK_W) ? NUM_ALUS : ALU_MASK_W;
    localparam logic [ALU_MASK_W-1:0] ALU_MASK = ALU_MASK_W'((1 << ALU_LIM) - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_EVAL,
        ST_FLUSH
    } state_t;

    state_t                state_reg,      state_next;
    logic [CNT_W-1:0]      count_reg,      count_next;
    logic [IDX_W-1:0]      idx_reg,        idx_next;
    logic [CNT_W-1:0]      keep_reg,       keep_next;
    logic                  scan_tick_reg,  scan_tick_next;
    logic [ALU_MASK_W-1:0] alu_ok_reg,     alu_ok_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic                  out_valid_reg,  out_valid_next;
    logic [TAG_W-1:0]      fwd_tag_reg,    fwd_tag_next;
    logic [DATA_W-1:0]     fwd_value_reg,  fwd_value_next;
    result_t               pend_res_reg,   pend_res_next;
    result_t               out_res_reg,    out_res_next;
    logic                  out_last_reg,   out_last_next;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    entry_t                wr_data;
    logic                  rd_en;
    entry_t                rd_data;
    entry_t                woken;
    step_res_t             pick;
    entry_t                new_entry;
    logic                  out_free;
    logic                  last_idx;
    logic                  tag_in_range;
    logic                  step_go;

    iqws_slot_ram #(
        .DEPTH (QUEUE_DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    iqws_step_unit u_step_unit (
        .entry     (rd_data),
        .fwd_tag   (fwd_tag_reg),
        .fwd_value (fwd_value_reg),
        .alu_ok    (alu_ok_reg),
        .woken     (woken),
        .pick      (pick)
    );

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_free     = !out_valid_reg || out_ready;
    assign last_idx     = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign tag_in_range = ({3'b000, a_tag} < 9'(NUM_PHYS_REGS));

    always_comb
    begin
        new_entry.dest    = dest_reg;
        new_entry.opcode  = opcode;
        new_entry.pc      = pc;
        new_entry.a_ready = a_ready;
        new_entry.a_tag   = a_tag;
        new_entry.a_value = a_value;
        new_entry.b_ready = b_ready;
        new_entry.b_tag   = b_tag;
        new_entry.b_value = b_value;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        keep_next       = keep_reg;
        scan_tick_next  = scan_tick_reg;
        alu_ok_next     = alu_ok_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        fwd_tag_next    = fwd_tag_reg;
        fwd_value_next  = fwd_value_reg;
        pend_res_next   = pend_res_reg;
        out_res_next    = out_res_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = rd_data;
        rd_en           = 1'b0;
        step_go         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (req_type)
                        REQ_INSERT:
                        begin
                            if (count_reg == FULL_COUNT)
                            begin
                                pend_res_next      = '0;
                                pend_res_next.kind = KIND_FULL;
                                pend_valid_next    = 1'b1;
                                state_next         = ST_FLUSH;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IDX_W-1:0];
                                wr_data    = new_entry;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_FORWARD:
                        begin
                            if (!exception_flag && tag_in_range && count_reg != '0)
                            begin
                                fwd_tag_next   = a_tag;
                                fwd_value_next = a_value;
                                scan_tick_next = 1'b0;
                                idx_next       = '0;
                                state_next     = ST_RD;
                            end
                        end
                        REQ_TICK:
                        begin
                            // no free ALU: nothing issues and nothing moves
                            if (!exception_flag && count_reg != '0
                                && (alu_free_mask & ALU_MASK) != '0)
                            begin
                                alu_ok_next    = alu_free_mask & ALU_MASK;
                                scan_tick_next = 1'b1;
                                idx_next       = '0;
                                keep_next      = '0;
                                state_next     = ST_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_EVAL;
            end

            ST_EVAL:
            begin
                if (!scan_tick_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg;
                    wr_data = woken;
                    step_go = 1'b1;
                end
                else if (pick.issue)
                begin
                    // hold the walk until the previous item can move out
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_res_next   = pend_res_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_res_next.kind      = KIND_ISSUE;
                        pend_res_next.alu_index = pick.alu_index;
                        pend_res_next.dest      = rd_data.dest;
                        pend_res_next.opcode    = rd_data.opcode;
                        pend_res_next.pc        = rd_data.pc;
                        pend_res_next.operand_a = rd_data.a_value;
                        pend_res_next.operand_b = rd_data.b_value;
                        pend_valid_next         = 1'b1;
                        alu_ok_next             = pick.alu_ok;
                        step_go                 = 1'b1;
                    end
                end
                else
                begin
                    // compact: slide the surviving entry down to the keep point
                    wr_en     = 1'b1;
                    wr_addr   = keep_reg[IDX_W-1:0];
                    wr_data   = rd_data;
                    keep_next = keep_reg + CNT_W'(1);
                    step_go   = 1'b1;
                end

                if (step_go)
                begin
                    if (last_idx)
                    begin
                        if (scan_tick_reg)
                        begin
                            count_next = keep_next;
                        end
                        state_next = pend_valid_next ? ST_FLUSH : ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_RD;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_res_next    = pend_res_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            keep_reg       <= '0;
            scan_tick_reg  <= 1'b0;
            alu_ok_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            keep_reg       <= keep_next;
            scan_tick_reg  <= scan_tick_next;
            alu_ok_reg     <= alu_ok_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_tag_reg   <= fwd_tag_next;
        fwd_value_reg <= fwd_value_next;
        pend_res_reg  <= pend_res_next;
        out_res_reg   <= out_res_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign kind       = out_res_reg.kind;
    assign alu_index  = out_res_reg.alu_index;
    assign out_dest   = out_res_reg.dest;
    assign out_opcode = out_res_reg.opcode;
    assign out_pc     = out_res_reg.pc;
    assign operand_a  = out_res_reg.operand_a;
    assign operand_b  = out_res_reg.operand_b;
    assign last       = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("queue occupancy beyond depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && req_type == REQ_INSERT && count_reg != FULL_COUNT)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("accepted insert did not grow the queue");

    a_keep_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && scan_tick_reg) |-> keep_reg <= CNT_W'(idx_reg))
        else $error("compaction point ahead of scan point");

    a_alu_only_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> (alu_ok_reg & ~$past(alu_ok_reg)) == '0)
        else $error("free ALU set grew during a tick");

    a_full_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.kind == KIND_FULL) |-> out_last_reg)
        else $error("refused insert item not marked last");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the issue queue: insert, wakeup, select and full-queue refusal.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iqws_pkg::*;

    localparam int QUEUE_DEPTH   = 32;
    localparam int NUM_ALUS      = 4;
    localparam int NUM_PHYS_REGS = 64;
    localparam int ALU_LIMIT     = NUM_ALUS < 4 ? NUM_ALUS : 4;
    localparam logic [ALU_MASK_W-1:0] ALU_USABLE = ALU_MASK_W'((1 << ALU_LIMIT) - 1);
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int TARGET_ITEMS  = 310;
    localparam int BACKLOG_HOLD  = 300;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        logic [1:0]            req;
        logic [TAG_W-1:0]      dest;
        logic [OPC_W-1:0]      opcode;
        logic [DATA_W-1:0]     pc;
        logic                  a_ready;
        logic [TAG_W-1:0]      a_tag;
        logic [DATA_W-1:0]     a_value;
        logic                  b_ready;
        logic [TAG_W-1:0]      b_tag;
        logic [DATA_W-1:0]     b_value;
        logic [ALU_MASK_W-1:0] mask;
        logic                  exc;
    } req_item_t;

    typedef struct packed {
        result_t res;
        logic    last;
    } issue_out_t;

    // Queue model plus the store of issues and refusals still owed by the block.
    class issue_scoreboard;
        entry_t     slots[$];
        issue_out_t owed[$];
        int         mismatches;
        int         results_seen;
        int         refused;
        int         widest_tick;

        function new();
            mismatches   = 0;
            results_seen = 0;
            refused      = 0;
            widest_tick  = 0;
        endfunction

        function int occupancy();
            return slots.size();
        endfunction

        function bit waiting_tag(output logic [TAG_W-1:0] tag);
            logic [TAG_W-1:0] pool[$];
            foreach (slots[i])
            begin
                if (!slots[i].a_ready)
                    pool.push_back(slots[i].a_tag);
                if (!slots[i].b_ready)
                    pool.push_back(slots[i].b_tag);
            end
            tag = '0;
            if (pool.size() == 0)
                return 1'b0;
            tag = pool[$urandom_range(pool.size() - 1)];
            return 1'b1;
        endfunction

        function void note_item(req_item_t it);
            entry_t                e;
            issue_out_t            r;
            issue_out_t            issued[$];
            entry_t                kept[$];
            logic [ALU_MASK_W-1:0] alu_ok;
            int                    a;
            case (it.req)
                REQ_INSERT:
                begin
                    if (slots.size() >= QUEUE_DEPTH)
                    begin
                        r = '0;
                        r.res.kind = KIND_FULL;
                        r.last = 1'b1;
                        owed.push_back(r);
                        refused++;
                    end
                    else
                    begin
                        e.dest    = it.dest;
                        e.opcode  = it.opcode;
                        e.pc      = it.pc;
                        e.a_ready = it.a_ready;
                        e.a_tag   = it.a_tag;
                        e.a_value = it.a_value;
                        e.b_ready = it.b_ready;
                        e.b_tag   = it.b_tag;
                        e.b_value = it.b_value;
                        slots.push_back(e);
                    end
                end
                REQ_FORWARD:
                begin
                    if (!it.exc && it.a_tag < NUM_PHYS_REGS)
                    begin
                        // wake waiting operands only; ready ones keep their value
                        foreach (slots[i])
                        begin
                            if (!slots[i].a_ready && slots[i].a_tag == it.a_tag)
                            begin
                                slots[i].a_ready = 1'b1;
                                slots[i].a_value = it.a_value;
                            end
                            if (!slots[i].b_ready && slots[i].b_tag == it.a_tag)
                            begin
                                slots[i].b_ready = 1'b1;
                                slots[i].b_value = it.a_value;
                            end
                        end
                    end
                end
                REQ_TICK:
                begin
                    if (!it.exc)
                    begin
                        alu_ok = it.mask & ALU_USABLE;
                        foreach (slots[i])
                        begin
                            if (alu_ok != '0 && slots[i].a_ready && slots[i].b_ready)
                            begin
                                a = 0;
                                while (!alu_ok[a])
                                    a++;
                                alu_ok[a] = 1'b0;
                                r = '0;
                                r.res.kind      = KIND_ISSUE;
                                r.res.alu_index = a[ALU_IDX_W-1:0];
                                r.res.dest      = slots[i].dest;
                                r.res.opcode    = slots[i].opcode;
                                r.res.pc        = slots[i].pc;
                                r.res.operand_a = slots[i].a_value;
                                r.res.operand_b = slots[i].b_value;
                                issued.push_back(r);
                            end
                            else
                                kept.push_back(slots[i]);
                        end
                        // compact, keeping age order
                        slots = kept;
                        if (issued.size() > 0)
                            issued[issued.size() - 1].last = 1'b1;
                        if (issued.size() > widest_tick)
                            widest_tick = issued.size();
                        foreach (issued[k])
                            owed.push_back(issued[k]);
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function string show(issue_out_t o);
            return $sformatf("kind=%0d alu=%0d dest=%0d opc=%0d pc=%h a=%h b=%h last=%0d",
                             o.res.kind, o.res.alu_index, o.res.dest, o.res.opcode,
                             o.res.pc, o.res.operand_a, o.res.operand_b, o.last);
        endfunction

        function void check_result(issue_out_t got);
            issue_out_t want;
            results_seen++;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] result with nothing owed: %s", $time, show(got));
                return;
            end
            want = owed.pop_front();
            if (got.res.kind !== want.res.kind || got.res.alu_index !== want.res.alu_index
                || got.res.dest !== want.res.dest || got.res.opcode !== want.res.opcode
                || got.res.pc !== want.res.pc || got.res.operand_a !== want.res.operand_a
                || got.res.operand_b !== want.res.operand_b || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("[%0t] result error, want: %s", $time, show(want));
                    $display("[%0t]               got:  %s", $time, show(got));
                end
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            req_type;
    logic [TAG_W-1:0]      dest_reg;
    logic [OPC_W-1:0]      opcode;
    logic [DATA_W-1:0]     pc;
    logic                  a_ready;
    logic [TAG_W-1:0]      a_tag;
    logic [DATA_W-1:0]     a_value;
    logic                  b_ready;
    logic [TAG_W-1:0]      b_tag;
    logic [DATA_W-1:0]     b_value;
    logic [ALU_MASK_W-1:0] alu_free_mask;
    logic                  exception_flag;
    logic                  out_valid;
    logic                  out_ready;
    logic                  kind;
    logic [ALU_IDX_W-1:0]  alu_index;
    logic [TAG_W-1:0]      out_dest;
    logic [OPC_W-1:0]      out_opcode;
    logic [DATA_W-1:0]     out_pc;
    logic [DATA_W-1:0]     operand_a;
    logic [DATA_W-1:0]     operand_b;
    logic                  last;

    issue_scoreboard model = new();
    bit              calm;
    bit              hold_req;
    int              items_done;

    issue_queue_wakeup_select_top #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .NUM_ALUS     (NUM_ALUS),
        .NUM_PHYS_REGS(NUM_PHYS_REGS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .dest_reg      (dest_reg),
        .opcode        (opcode),
        .pc            (pc),
        .a_ready       (a_ready),
        .a_tag         (a_tag),
        .a_value       (a_value),
        .b_ready       (b_ready),
        .b_tag         (b_tag),
        .b_value       (b_value),
        .alu_free_mask (alu_free_mask),
        .exception_flag(exception_flag),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .alu_index     (alu_index),
        .out_dest      (out_dest),
        .out_opcode    (out_opcode),
        .out_pc        (out_pc),
        .operand_a     (operand_a),
        .operand_b     (operand_b),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    // Result side: check each accepted item, then pick the next ready level.
    initial
    begin
        issue_out_t got;
        int         hold_left;
        out_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.res.kind      = kind;
                got.res.alu_index = alu_index;
                got.res.dest      = out_dest;
                got.res.opcode    = out_opcode;
                got.res.pc        = out_pc;
                got.res.operand_a = operand_a;
                got.res.operand_b = operand_b;
                got.last          = last;
                model.check_result(got);
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = BACKLOG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= rst_n && (calm || $urandom_range(99) >= 31);
        end
    end

    task automatic pause_sender();
        int n;
        n = 0;
        if (!calm)
            while ($urandom_range(99) < 31)
                n++;
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_item(req_item_t it);
        in_valid       <= 1'b1;
        req_type       <= it.req;
        dest_reg       <= it.dest;
        opcode         <= it.opcode;
        pc             <= it.pc;
        a_ready        <= it.a_ready;
        a_tag          <= it.a_tag;
        a_value        <= it.a_value;
        b_ready        <= it.b_ready;
        b_tag          <= it.b_tag;
        b_value        <= it.b_value;
        alu_free_mask  <= it.mask;
        exception_flag <= it.exc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        model.note_item(it);
        items_done++;
        pause_sender();
    endtask

    function automatic req_item_t rand_item(logic [1:0] req);
        req_item_t it;
        it.req     = req;
        it.dest    = TAG_W'($urandom);
        it.opcode  = OPC_W'($urandom);
        it.pc      = {$urandom, $urandom};
        it.a_ready = 1'($urandom);
        it.a_tag   = TAG_W'($urandom);
        it.a_value = {$urandom, $urandom};
        it.b_ready = 1'($urandom);
        it.b_tag   = TAG_W'($urandom);
        it.b_value = {$urandom, $urandom};
        it.mask    = ALU_MASK_W'($urandom);
        it.exc     = 1'b0;
        return it;
    endfunction

    function automatic req_item_t make_insert(int ready_pct);
        req_item_t        it;
        logic [TAG_W-1:0] t;
        it = rand_item(REQ_INSERT);
        it.a_ready = $urandom_range(99) < ready_pct;
        it.b_ready = $urandom_range(99) < ready_pct;
        // share producer tags so one forward wakes several operands
        if ($urandom_range(99) < 40 && model.waiting_tag(t))
            it.a_tag = t;
        if ($urandom_range(99) < 40 && model.waiting_tag(t))
            it.b_tag = t;
        it.exc = $urandom_range(99) < 10;
        return it;
    endfunction

    function automatic req_item_t make_forward(int exc_pct);
        req_item_t        it;
        logic [TAG_W-1:0] t;
        it = rand_item(REQ_FORWARD);
        if ($urandom_range(99) < 85 && model.waiting_tag(t))
            it.a_tag = t;
        it.exc = $urandom_range(99) < exc_pct;
        return it;
    endfunction

    function automatic req_item_t make_tick(int exc_pct);
        req_item_t it;
        it = rand_item(REQ_TICK);
        if ($urandom_range(99) < 50)
            it.mask = '1;
        it.exc = $urandom_range(99) < exc_pct;
        return it;
    endfunction

    task automatic run_drain();
        logic [TAG_W-1:0] t;
        req_item_t        it;
        int               guard;
        guard = 0;
        while (model.occupancy() > 0 && guard < 300)
        begin
            if ($urandom_range(99) < 60 && model.waiting_tag(t))
                it = make_forward(0);
            else
            begin
                it = make_tick(0);
                if (it.mask == '0)
                    it.mask = '1;
            end
            send_item(it);
            guard++;
        end
    endtask

    // Fill to the brim, push a few refused inserts, then empty it again.
    task automatic run_fill();
        int extra;
        while (model.occupancy() < QUEUE_DEPTH)
            send_item(make_insert(30));
        extra = $urandom_range(1, 3);
        repeat (extra) send_item(make_insert(50));
        run_drain();
    endtask

    task automatic run_dataflow();
        int k;
        int m;
        int pick;
        k = $urandom_range(1, 6);
        repeat (k) send_item(make_insert(50));
        m = $urandom_range(2, 8);
        repeat (m)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_item(make_forward(10));
            else if (pick < 85)
                send_item(make_tick(10));
            else
                send_item(make_insert(50));
        end
    endtask

    task automatic run_noise();
        req_item_t it;
        int        k;
        k = $urandom_range(1, 6);
        repeat (k)
        begin
            it = rand_item(2'($urandom));
            it.exc = 1'($urandom);
            send_item(it);
        end
    endtask

    // Stall the result side while ready work keeps arriving.
    task automatic run_backlog();
        hold_req = 1'b1;
        repeat (6) send_item(make_insert(100));
        send_item(make_tick(0));
        repeat (4) send_item(make_insert(100));
        repeat (3)
        begin
            send_item(make_tick(0));
        end
        run_drain();
    endtask

    task automatic run_directed();
        req_item_t it;
        // tick on an empty queue
        it = rand_item(REQ_TICK);
        it.mask = '1;
        send_item(it);
        // extreme fields, ready operands, exception on insert
        it = rand_item(REQ_INSERT);
        it.dest = '1; it.opcode = '1; it.pc = '1;
        it.a_ready = 1'b1; it.a_tag = '1; it.a_value = '1;
        it.b_ready = 1'b1; it.b_tag = '1; it.b_value = '1;
        it.exc = 1'b1;
        send_item(it);
        it = rand_item(REQ_INSERT);
        it.dest = '0; it.opcode = '0; it.pc = '0;
        it.a_ready = 1'b0; it.a_tag = '1;
        it.b_ready = 1'b0; it.b_tag = '0;
        send_item(it);
        // operand A ready but carrying the same tag that B waits on
        it = rand_item(REQ_INSERT);
        it.a_ready = 1'b1; it.a_tag = 6'd5;
        it.b_ready = 1'b0; it.b_tag = 6'd5;
        send_item(it);
        // forward under exception must be dropped
        it = rand_item(REQ_FORWARD);
        it.a_tag = 6'd5; it.exc = 1'b1;
        send_item(it);
        it = rand_item(REQ_FORWARD);
        it.a_tag = 6'd5;
        send_item(it);
        it = rand_item(REQ_UNKNOWN);
        send_item(it);
        it = rand_item(REQ_TICK);
        it.mask = '1; it.exc = 1'b1;
        send_item(it);
        it = rand_item(REQ_TICK);
        it.mask = '0;
        send_item(it);
        // one ALU free: only the oldest ready entry leaves
        it = rand_item(REQ_TICK);
        it.mask = 4'b1000;
        send_item(it);
        it = rand_item(REQ_FORWARD);
        it.a_tag = '1; it.a_value = '1;
        send_item(it);
        it = rand_item(REQ_FORWARD);
        it.a_tag = '0; it.a_value = '0;
        send_item(it);
        it = rand_item(REQ_TICK);
        it.mask = '1;
        send_item(it);
        repeat (4) send_item(make_insert(100));
        it = rand_item(REQ_TICK);
        it.mask = 4'b0110;
        send_item(it);
        it = rand_item(REQ_TICK);
        it.mask = 4'b0101;
        send_item(it);
        repeat (4) send_item(make_insert(100));
        it = rand_item(REQ_TICK);
        it.mask = '1;
        send_item(it);
    endtask

    initial
    begin
        int  pick;
        bit  backlog_done;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        req_type       = REQ_INSERT;
        dest_reg       = '0;
        opcode         = '0;
        pc             = '0;
        a_ready        = 1'b0;
        a_tag          = '0;
        a_value        = '0;
        b_ready        = 1'b0;
        b_tag          = '0;
        b_value        = '0;
        alu_free_mask  = '0;
        exception_flag = 1'b0;
        calm           = 1'b0;
        hold_req       = 1'b0;
        items_done     = 0;
        backlog_done   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_fill();
        while (items_done < TARGET_ITEMS)
        begin
            calm = items_done >= 120 && items_done < 180;
            if (!backlog_done && items_done >= 200)
            begin
                run_backlog();
                backlog_done = 1'b1;
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                    run_dataflow();
                else if (pick < 70)
                    run_drain();
                else if (pick < 80)
                    run_fill();
                else
                    run_noise();
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (model.owed.size() != 0)
            @(posedge clk);
        // a tick over a full queue walks every slot before it settles
        repeat (100) @(posedge clk);

        $display("Covered %0d items, %0d inserts refused on a full queue,",
                 items_done, model.refused);
        $display("up to %0d issues per tick; checked %0d results, %0d in error",
                 model.widest_tick, model.results_seen, model.mismatches);
        if (model.mismatches == 0 && model.owed.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
